// ===== sv/ohlc_pkg.sv =====
// ----------------------------------------------------------------------------
// ohlc_pkg
// shared widths, word layouts and control/status bundles of the bar aggregator
// ----------------------------------------------------------------------------
package ohlc_pkg;

  localparam int unsigned TsBits     = 48;
  localparam int unsigned PxBits     = 32;
  localparam int unsigned QtyBits    = 32;
  localparam int unsigned AmtBits    = 48;
  localparam int unsigned SumBits    = 40;
  localparam int unsigned IvBits     = 30;
  localparam int unsigned RemBits    = IvBits + 1;
  localparam int unsigned DivCntBits = 6;

  localparam logic [IvBits-1:0] IntervalMin   = IvBits'(1000);
  localparam logic [IvBits-1:0] IntervalMax   = IvBits'(604800000);
  localparam logic [IvBits-1:0] IntervalReset = IvBits'(60000);
  localparam logic [DivCntBits-1:0] DivLast   = DivCntBits'(TsBits - 1);

  // last declared field in the lowest bits
  typedef struct packed {
    logic [QtyBits-1:0] ask_qty;
    logic [PxBits-1:0]  ask_px;
    logic [QtyBits-1:0] bid_qty;
    logic [PxBits-1:0]  bid_px;
    logic [AmtBits-1:0] trade_amount;
    logic [QtyBits-1:0] trade_volume;
    logic [PxBits-1:0]  trade_price;
    logic [TsBits-1:0]  timestamp_ms;
  } tick_t;

  typedef struct packed {
    logic [SumBits-1:0] ask_qty_sum;
    logic [PxBits-1:0]  last_ask_px;
    logic [SumBits-1:0] bid_qty_sum;
    logic [PxBits-1:0]  last_bid_px;
    logic [AmtBits-1:0] bar_amount;
    logic [SumBits-1:0] bar_volume;
    logic [PxBits-1:0]  close_price;
    logic [PxBits-1:0]  low_price;
    logic [PxBits-1:0]  high_price;
    logic [PxBits-1:0]  open_price;
    logic [TsBits-1:0]  bar_start_ms;
  } bar_t;

  localparam int unsigned TickBits = $bits(tick_t);
  localparam int unsigned BarBits  = $bits(bar_t);

  typedef struct packed {
    logic load_tick;
    logic div_start;
    logic div_step;
    logic align;
    logic accum;
    logic out_load;
    logic out_last;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic need_align;
    logic close_bar;
    logic started;
    logic eob;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/ohlc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ohlc_ctrl
// sequencer: tick intake, bar close, window alignment, accumulate, flush
// ----------------------------------------------------------------------------
module ohlc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ohlc_pkg::sts_t sts_i,
  output ohlc_pkg::cmd_t cmd_o
);
  import ohlc_pkg::*;

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StCheck = 7'b0000010,
    StClose = 7'b0000100,
    StDiv   = 7'b0001000,
    StAlign = 7'b0010000,
    StAccum = 7'b0100000,
    StFlush = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_tick = 1'b1;
          state_d = StCheck;
        end
      end
      StCheck: begin
        if (sts_i.close_bar) begin
          state_d = StClose;
        end else if (sts_i.need_align) begin
          cmd_o.div_start = 1'b1;
          state_d = StDiv;
        end else begin
          state_d = StAccum;
        end
      end
      StClose: begin
        if (sts_i.out_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.out_last  = ~sts_i.eob;
          cmd_o.div_start = 1'b1;
          state_d = StDiv;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = StAlign;
        end
      end
      StAlign: begin
        cmd_o.align = 1'b1;
        state_d = StAccum;
      end
      StAccum: begin
        cmd_o.accum = 1'b1;
        state_d = sts_i.eob ? StFlush : StIdle;
      end
      StFlush: begin
        if (!sts_i.started) begin
          cmd_o.clear = 1'b1;
          state_d = StIdle;
        end else if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = 1'b1;
          cmd_o.clear    = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/ohlc_datapath.sv =====
// ----------------------------------------------------------------------------
// ohlc_datapath
// tick register, interval register, serial remainder unit, bar accumulators
// and output word register
// ----------------------------------------------------------------------------
module ohlc_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ohlc_pkg::IvBits-1:0]  cfg_wdata_i,
  input  ohlc_pkg::tick_t              tick_i,
  input  logic                         eob_i,
  input  ohlc_pkg::cmd_t               cmd_i,
  output ohlc_pkg::sts_t               sts_o,
  output ohlc_pkg::bar_t               bar_o,
  output logic                         bar_last_o,
  output logic                         bar_valid_o,
  input  logic                         bar_ready_i
);
  import ohlc_pkg::*;

  logic [IvBits-1:0]     iv_q;
  logic [IvBits-1:0]     iv;
  tick_t                 tick_q;
  logic                  eob_q;
  logic                  valid_q, started_q;
  logic [TsBits-1:0]     ws_q;
  bar_t                  acc_q, acc_d;
  logic [TsBits-1:0]     dvd_q;
  logic [RemBits-1:0]    rem_q, rem_shift;
  logic [DivCntBits-1:0] cnt_q;
  logic [TsBits:0]       win_end;
  logic                  past_end, late;
  bar_t                  out_q;
  logic                  out_last_q, out_valid_q;
  logic [SumBits:0]      vol_s, bq_s, aq_s;
  logic [AmtBits:0]      amt_s;
  logic [PxBits-1:0]     hi_b, lo_b;
  logic [SumBits-1:0]    vol_b, bq_b, aq_b;
  logic [AmtBits-1:0]    amt_b;

  always_comb begin
    iv = iv_q;
    if (iv_q < IntervalMin) iv = IntervalMin;
    if (iv_q > IntervalMax) iv = IntervalMax;
  end

  assign win_end  = {1'b0, ws_q} + (TsBits+1)'(iv);
  assign past_end = {1'b0, tick_q.timestamp_ms} >= win_end;
  assign late     = tick_q.timestamp_ms < ws_q;

  assign sts_o.need_align = ~valid_q | past_end;
  assign sts_o.close_bar  = valid_q & past_end & started_q;
  assign sts_o.started    = started_q;
  assign sts_o.eob        = eob_q;
  assign sts_o.div_last   = (cnt_q == DivLast);
  assign sts_o.out_free   = ~out_valid_q | bar_ready_i;

  assign rem_shift = {rem_q[RemBits-2:0], dvd_q[TsBits-1]};

  // new bar opens from the tick itself
  always_comb begin
    hi_b  = started_q ? acc_q.high_price  : tick_q.trade_price;
    lo_b  = started_q ? acc_q.low_price   : tick_q.trade_price;
    vol_b = started_q ? acc_q.bar_volume  : '0;
    amt_b = started_q ? acc_q.bar_amount  : '0;
    bq_b  = started_q ? acc_q.bid_qty_sum : '0;
    aq_b  = started_q ? acc_q.ask_qty_sum : '0;
    vol_s = {1'b0, vol_b} + (SumBits+1)'(tick_q.trade_volume);
    amt_s = {1'b0, amt_b} + {1'b0, tick_q.trade_amount};
    bq_s  = {1'b0, bq_b} + (SumBits+1)'(tick_q.bid_qty);
    aq_s  = {1'b0, aq_b} + (SumBits+1)'(tick_q.ask_qty);

    acc_d = acc_q;
    acc_d.bar_start_ms = ws_q;
    if (!started_q) begin
      acc_d.open_price  = tick_q.trade_price;
      acc_d.last_bid_px = '0;
      acc_d.bid_qty_sum = '0;
      acc_d.last_ask_px = '0;
      acc_d.ask_qty_sum = '0;
    end
    acc_d.high_price  = (tick_q.trade_price > hi_b) ? tick_q.trade_price : hi_b;
    acc_d.low_price   = (tick_q.trade_price < lo_b) ? tick_q.trade_price : lo_b;
    acc_d.close_price = tick_q.trade_price;
    acc_d.bar_volume  = vol_s[SumBits] ? '1 : vol_s[SumBits-1:0];
    acc_d.bar_amount  = amt_s[AmtBits] ? '1 : amt_s[AmtBits-1:0];
    if (tick_q.bid_px != '0) begin
      acc_d.last_bid_px = tick_q.bid_px;
      acc_d.bid_qty_sum = bq_s[SumBits] ? '1 : bq_s[SumBits-1:0];
    end
    if (tick_q.ask_px != '0) begin
      acc_d.last_ask_px = tick_q.ask_px;
      acc_d.ask_qty_sum = aq_s[SumBits] ? '1 : aq_s[SumBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q        <= IntervalReset;
      valid_q     <= 1'b0;
      started_q   <= 1'b0;
      ws_q        <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (cfg_we_i) iv_q <= cfg_wdata_i;
      if (cmd_i.div_start) begin
        cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.align) begin
        ws_q      <= tick_q.timestamp_ms - TsBits'(rem_q);
        valid_q   <= 1'b1;
        started_q <= 1'b0;
      end
      if (cmd_i.accum && !late) begin
        acc_q     <= acc_d;
        started_q <= 1'b1;
      end
      if (cmd_i.clear) begin
        valid_q   <= 1'b0;
        started_q <= 1'b0;
        ws_q      <= '0;
        acc_q     <= '0;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (bar_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // a started bar always carries the current window start
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_tick) begin
      tick_q <= tick_i;
      eob_q  <= eob_i;
    end
    if (cmd_i.div_start) begin
      dvd_q <= tick_q.timestamp_ms;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[TsBits-2:0], 1'b0};
      rem_q <= (rem_shift >= RemBits'(iv)) ? rem_shift - RemBits'(iv) : rem_shift;
    end
    if (cmd_i.out_load) begin
      out_q      <= acc_q;
      out_last_q <= cmd_i.out_last;
    end
  end

  assign bar_o       = out_q;
  assign bar_last_o  = out_last_q;
  assign bar_valid_o = out_valid_q;

endmodule

// ===== sv/tick_to_ohlc_bar_aggregator.sv =====
// ----------------------------------------------------------------------------
// tick_to_ohlc_bar_aggregator
// gathers market ticks into open/high/low/close bars over aligned windows
// ----------------------------------------------------------------------------
// channel   dir  word                          tlast / notes
// s_axis    in   tick, 288 bits                end_of_batch
// m_axis    out  bar, 408 bits                 last_of_run
// cfg       in   interval_ms, 30 bits          written when cfg_we_i is high
//
// a tick in the current window passes the check and accumulate states, and
// the flush state on end of batch; for a tick opening a new window, the window
// start comes from a 48-step serial remainder unit, one timestamp bit a cycle
// a stalled m_axis holds the sequencer only where a bar must be sent
// reset clears the bar accumulators and window state and sets the interval to 60000 ms
// ----------------------------------------------------------------------------
module tick_to_ohlc_bar_aggregator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ohlc_pkg::IvBits-1:0]   cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // timestamp_ms, trade_price, trade_volume, trade_amount, bid_px, bid_qty,
  // ask_px, ask_qty
  input  logic [ohlc_pkg::TickBits-1:0] s_axis_tdata,
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // bar_start_ms, open_price, high_price, low_price, close_price, bar_volume,
  // bar_amount, last_bid_px, bid_qty_sum, last_ask_px, ask_qty_sum
  output logic [ohlc_pkg::BarBits-1:0]  m_axis_tdata,
  output logic                          m_axis_tlast
);
  import ohlc_pkg::*;

  cmd_t cmd;
  sts_t sts;
  bar_t bar;

  ohlc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ohlc_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .tick_i      (tick_t'(s_axis_tdata)),
    .eob_i       (s_axis_tlast),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .bar_o       (bar),
    .bar_last_o  (m_axis_tlast),
    .bar_valid_o (m_axis_tvalid),
    .bar_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = bar;

endmodule
